FILE: rtl/etbr_pkg.sv
// Shared types, constants and helpers for the edge-timed bus responder.
package etbr_pkg;

  // Default sizes of the framing
  localparam int DATA_BITS_DEF    = 32;
  localparam int ADDRESS_BITS_DEF = 8;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int ADDR_W  = 8;
  localparam int PAY_W   = 24;
  localparam int PER_W   = 16;
  localparam int CNT_W   = 6;
  localparam int WORD_W  = 32;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 24;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 72;

  // Register reset values
  localparam logic [ADDR_W-1:0] NODE_ADDR_RST = 8'd1;
  localparam logic [PER_W-1:0]  PULSE_RST     = 16'd50;
  localparam logic [PER_W-1:0]  BIT_RST       = 16'd500;
  localparam logic [ADDR_W-1:0] TEST_ON_RST   = 8'd255;
  localparam logic [ADDR_W-1:0] TEST_OFF_RST  = 8'd254;

  // Register indexes on the write port
  typedef enum logic [CFG_IW-1:0] {
    REG_NODE_ADDRESS  = 3'd0,
    REG_IS_LISTENER   = 3'd1,
    REG_RESPONSE_DATA = 3'd2,
    REG_TEST_DATA     = 3'd3,
    REG_PULSE_PERIOD  = 3'd4,
    REG_BIT_PERIOD    = 3'd5,
    REG_TEST_ON_ADDR  = 3'd6,
    REG_TEST_OFF_ADDR = 3'd7
  } cfg_idx_t;

  // Configuration as seen by the frame logic; thresholds are prescaled
  typedef struct packed {
    logic [ADDR_W-1:0]  node_address;
    logic               is_listener;
    logic [PAY_W-1:0]   response_data;
    logic [PAY_W-1:0]   test_data;
    logic [PER_W+1:0]   ignore_limit;   // 3 x pulse period
    logic [PER_W:0]     restart_limit;  // 2 x bit period
    logic [ADDR_W-1:0]  test_on_address;
    logic [ADDR_W-1:0]  test_off_address;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic              test_mode_active;
    logic [WORD_W-1:0] received_value;
    logic              word_received;
    logic [WORD_W-1:0] response_word;
    logic              send_response;
  } result_t;

  // Checksum byte on top of the 24-bit payload
  function automatic logic [WORD_W-1:0] with_checksum(input logic [ADDR_W-1:0] seed,
                                                      input logic [PAY_W-1:0]  payload);
    logic [7:0] sum;
    sum = seed + payload[7:0] + payload[15:8] + payload[23:16];
    return {sum, payload};
  endfunction

endpackage

FILE: rtl/etbr_cfg_regs.sv
// Configuration register file with prescaled timing thresholds.
module etbr_cfg_regs
  import etbr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wen,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output cfg_t              cfg
);

  logic [ADDR_W-1:0] node_address_r;
  logic              is_listener_r;
  logic [PAY_W-1:0]  response_data_r;
  logic [PAY_W-1:0]  test_data_r;
  logic [PER_W+1:0]  ignore_limit_r;
  logic [PER_W:0]    restart_limit_r;
  logic [ADDR_W-1:0] test_on_r;
  logic [ADDR_W-1:0] test_off_r;
  logic [PER_W-1:0]  per_w;

  assign per_w = cfg_wdata[PER_W-1:0];

  // Register writes; period registers store the scaled limits directly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_address_r  <= NODE_ADDR_RST;
      is_listener_r   <= 1'b1;
      response_data_r <= '0;
      test_data_r     <= '0;
      ignore_limit_r  <= {PULSE_RST, 1'b0} + {2'b00, PULSE_RST};
      restart_limit_r <= {BIT_RST, 1'b0};
      test_on_r       <= TEST_ON_RST;
      test_off_r      <= TEST_OFF_RST;
    end else if (cfg_wen) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_NODE_ADDRESS:  node_address_r  <= cfg_wdata[ADDR_W-1:0];
        REG_IS_LISTENER:   is_listener_r   <= cfg_wdata[0];
        REG_RESPONSE_DATA: response_data_r <= cfg_wdata[PAY_W-1:0];
        REG_TEST_DATA:     test_data_r     <= cfg_wdata[PAY_W-1:0];
        REG_PULSE_PERIOD:  ignore_limit_r  <= {1'b0, per_w, 1'b0} + {2'b00, per_w};
        REG_BIT_PERIOD:    restart_limit_r <= {per_w, 1'b0};
        REG_TEST_ON_ADDR:  test_on_r       <= cfg_wdata[ADDR_W-1:0];
        REG_TEST_OFF_ADDR: test_off_r      <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.node_address     = node_address_r;
  assign cfg.is_listener      = is_listener_r;
  assign cfg.response_data    = response_data_r;
  assign cfg.test_data        = test_data_r;
  assign cfg.ignore_limit     = ignore_limit_r;
  assign cfg.restart_limit    = restart_limit_r;
  assign cfg.test_on_address  = test_on_r;
  assign cfg.test_off_address = test_off_r;

endmodule

FILE: rtl/etbr_frame_core.sv
// Edge timing, bit framing, address decode and word assembly state.
module etbr_frame_core
  import etbr_pkg::*;
#(
  parameter int DATA_BITS    = DATA_BITS_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [TIME_W-1:0] edge_time,
  input  logic              line_level,
  input  cfg_t              cfg,
  output result_t           res
);

  logic [TIME_W-1:0] last_edge_r, last_edge_nxt;
  logic [CNT_W-1:0]  bits_r, bits_nxt;
  logic [CNT_W-1:0]  skip_r, skip_nxt;
  logic [WORD_W-1:0] shift_r, shift_nxt;
  logic              test_r, test_nxt;

  logic [TIME_W-1:0] delta;
  logic [WORD_W-1:0] shifted;
  logic [CNT_W-1:0]  bits_inc;
  logic [WORD_W-1:0] sext;

  assign delta    = edge_time - last_edge_r;
  assign shifted  = {shift_r[WORD_W-2:0], line_level};
  assign bits_inc = bits_r + 1'b1;

  // Sign extension of the assembled word from bit DATA_BITS-1
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      sext[i] = (i < DATA_BITS) ? shifted[i] : shifted[DATA_BITS-1];
    end
  end

  // Next state and result for one edge
  always_comb begin
    last_edge_nxt = last_edge_r;
    bits_nxt      = bits_r;
    skip_nxt      = skip_r;
    shift_nxt     = shift_r;
    test_nxt      = test_r;
    res           = '0;
    if (delta >= TIME_W'(cfg.ignore_limit)) begin
      last_edge_nxt = edge_time;
      if (delta > TIME_W'(cfg.restart_limit)) begin
        bits_nxt  = '0;
        skip_nxt  = '0;
        shift_nxt = '0;
      end else if (skip_r != '0) begin
        skip_nxt = skip_r - 1'b1;
      end else begin
        shift_nxt = shifted;
        bits_nxt  = bits_inc;
        if (cfg.is_listener && bits_inc == CNT_W'(ADDRESS_BITS)) begin
          // Address frame complete
          priority if (shifted == WORD_W'(cfg.node_address)) begin
            res.send_response = 1'b1;
            res.response_word = with_checksum(cfg.node_address,
                                              test_r ? cfg.test_data : cfg.response_data);
          end else if (shifted == WORD_W'(cfg.test_on_address)) begin
            test_nxt = 1'b1;
          end else if (shifted == WORD_W'(cfg.test_off_address)) begin
            test_nxt = 1'b0;
          end else begin
            skip_nxt = CNT_W'(DATA_BITS);
          end
          bits_nxt  = '0;
          shift_nxt = '0;
        end else if (!cfg.is_listener && bits_inc == CNT_W'(DATA_BITS)) begin
          // Data word complete
          res.word_received  = 1'b1;
          res.received_value = sext;
          bits_nxt  = '0;
          skip_nxt  = '0;
          shift_nxt = '0;
        end
      end
    end
    res.test_mode_active = test_nxt;
  end

  // State update on each edge that leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
      bits_r      <= '0;
      skip_r      <= '0;
      shift_r     <= '0;
      test_r      <= 1'b0;
    end else if (step) begin
      last_edge_r <= last_edge_nxt;
      bits_r      <= bits_nxt;
      skip_r      <= skip_nxt;
      shift_r     <= shift_nxt;
      test_r      <= test_nxt;
    end
  end

endmodule

FILE: rtl/edge_timed_bus_responder_top.sv
// Top level of the edge-timed bus responder: input stage, frame core, result register.
//
// Usage:
//   in_*   : one transfer per line edge (timestamp in us, level after the edge).
//   out_*  : exactly one result transfer per input transfer, in order: address
//            match with response word, completed requester word, and the test
//            mode flag after that edge.
//   cfg_*  : register writes, one per cycle with cfg_wen high; write only while
//            no edge is in flight.
// Path: an edge passes the input register, then the result register, which
//   drives out_tvalid and out_tdata.
// Throughput: one edge per cycle while the result register can advance; the edge
//   state (last time, counters, shift word, test flag) is updated by combinational
//   next-state logic as the edge leaves the input register.
// Reset: synchronous rst_n clears both stages, the edge state and the test
//   flag and loads the register defaults.
// Stall: while out_tready is low the result holds; the input register still
//   takes one more edge, after which in_tready drops until the result drains.
module edge_timed_bus_responder_top
  import etbr_pkg::*;
#(
  parameter int DATA_BITS    = DATA_BITS_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input edges
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [31:0] edge_time, [32] line_level, rest zero
  // Results
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [0] send_response, [32:1] response_word,
                                        // [33] word_received, [65:34] received_value,
                                        // [66] test_mode_active, rest zero
  // Configuration writes
  input  logic              cfg_wen,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic              in_valid_r;
  logic [TIME_W-1:0] in_time_r;
  logic              in_level_r;
  logic              out_valid_r;
  result_t           out_res_r;
  logic              advance;
  logic              step;
  cfg_t              cfg;
  result_t           res;

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  etbr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  etbr_frame_core #(
    .DATA_BITS    (DATA_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .edge_time  (in_time_r),
    .line_level (in_level_r),
    .cfg        (cfg),
    .res        (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_time_r  <= in_tdata[TIME_W-1:0];
      in_level_r <= in_tdata[TIME_W];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DW - $bits(result_t))'(0), out_res_r};

endmodule

FILE: rtl/etbr_checker.sv
// Port-level assertions for the edge-timed bus responder, bound to the top level.
module etbr_checker
  import etbr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata
);

  // A stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Listener answer and requester word never come from the same edge
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[33]))
    else $error("response and received word in one result");

  // No response means an empty response word
  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[32:1] == 32'd0)
    else $error("response word set without response");

  // No received word means an empty value, and padding stays zero
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[33] |-> out_tdata[65:34] == 32'd0 && out_tdata[71:67] == 5'd0)
    else $error("received value or padding set without word");

endmodule

bind edge_timed_bus_responder_top etbr_checker u_etbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/sv/edge_timed_bus_responder_checker.sv
// Stream monitor for the edge-timed bus responder: predicts every result and compares it.
module edge_timed_bus_responder_checker
  import etbr_pkg::*;
#(
  parameter int DATA_BITS    = DATA_BITS_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [31:0] edge_time, [32] line_level
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,  // [0] send_response, [32:1] response_word,
                                        // [33] word_received, [65:34] received_value,
                                        // [66] test_mode_active
  input  logic              cfg_wen,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                mismatch_count,
  output int                results_pending,
  output int                answers_seen,
  output int                words_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  logic [ADDR_W-1:0] node_addr, on_addr, off_addr;
  logic              listener;
  logic [PAY_W-1:0]  resp_payload, test_payload;
  logic [PER_W-1:0]  pulse_us, bit_us;

  // Framing state
  logic [TIME_W-1:0] last_time;
  logic [CNT_W-1:0]  bits_in, skip_left;
  logic [WORD_W-1:0] shift_reg;
  logic              test_on;

  result_t expected_results[$];

  // Advance the framing state by one edge and return the result it causes
  function automatic result_t predict_edge(input logic [TIME_W-1:0] stamp, input logic level);
    logic [TIME_W-1:0] gap;
    logic [WORD_W-1:0] mask;
    logic [PAY_W-1:0]  payload;
    logic [7:0]        sum;
    result_t           res;
    res  = '0;
    gap  = stamp - last_time;
    mask = {WORD_W{1'b1}} >> (WORD_W - DATA_BITS);
    if (gap >= {16'd0, pulse_us} * 32'd3) begin
      last_time = stamp;
      if (gap > {16'd0, bit_us} * 32'd2) begin
        // long silence: start framing over, no bit
        bits_in   = '0;
        skip_left = '0;
        shift_reg = '0;
      end else if (skip_left != '0) begin
        // data edges of another node
        skip_left = skip_left - 1'b1;
      end else begin
        shift_reg = {shift_reg[WORD_W-2:0], level};
        bits_in   = bits_in + 1'b1;
        if (listener && bits_in == CNT_W'(ADDRESS_BITS)) begin
          // own address wins, then test on, then test off
          if (shift_reg == WORD_W'(node_addr)) begin
            payload = test_on ? test_payload : resp_payload;
            sum     = node_addr + payload[7:0] + payload[15:8] + payload[23:16];
            res.send_response = 1'b1;
            res.response_word = {sum, payload};
          end else if (shift_reg == WORD_W'(on_addr)) begin
            test_on = 1'b1;
          end else if (shift_reg == WORD_W'(off_addr)) begin
            test_on = 1'b0;
          end else begin
            skip_left = CNT_W'(DATA_BITS);
          end
          bits_in   = '0;
          shift_reg = '0;
        end else if (!listener && bits_in == CNT_W'(DATA_BITS)) begin
          res.word_received  = 1'b1;
          res.received_value = shift_reg & mask;
          if (shift_reg[DATA_BITS-1]) begin
            res.received_value = res.received_value | ~mask;
          end
          bits_in   = '0;
          skip_left = '0;
          shift_reg = '0;
        end
      end
    end
    res.test_mode_active = test_on;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Snoop register writes and both streams
  always @(posedge clk) begin
    result_t seen, want;
    if (!rst_n) begin
      node_addr    = NODE_ADDR_RST;
      listener     = 1'b1;
      resp_payload = '0;
      test_payload = '0;
      pulse_us     = PULSE_RST;
      bit_us       = BIT_RST;
      on_addr      = TEST_ON_RST;
      off_addr     = TEST_OFF_RST;
      last_time    = '0;
      bits_in      = '0;
      skip_left    = '0;
      shift_reg    = '0;
      test_on      = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_idx_t'(cfg_index))
          REG_NODE_ADDRESS:  node_addr    = cfg_wdata[ADDR_W-1:0];
          REG_IS_LISTENER:   listener     = cfg_wdata[0];
          REG_RESPONSE_DATA: resp_payload = cfg_wdata[PAY_W-1:0];
          REG_TEST_DATA:     test_payload = cfg_wdata[PAY_W-1:0];
          REG_PULSE_PERIOD:  pulse_us     = cfg_wdata[PER_W-1:0];
          REG_BIT_PERIOD:    bit_us       = cfg_wdata[PER_W-1:0];
          REG_TEST_ON_ADDR:  on_addr      = cfg_wdata[ADDR_W-1:0];
          REG_TEST_OFF_ADDR: off_addr     = cfg_wdata[ADDR_W-1:0];
          default: ;
        endcase
      end
      // result transfer against the oldest prediction
      if (out_tvalid && out_tready) begin
        seen = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result transfer with nothing expected, got %h",
                   $time, out_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("send_response", WORD_W'(want.send_response),
                      WORD_W'(seen.send_response));
          check_field("response_word", want.response_word, seen.response_word);
          check_field("word_received", WORD_W'(want.word_received),
                      WORD_W'(seen.word_received));
          check_field("received_value", want.received_value, seen.received_value);
          check_field("test_mode_active", WORD_W'(want.test_mode_active),
                      WORD_W'(seen.test_mode_active));
          if (want.send_response) answers_seen++;
          if (want.word_received) words_seen++;
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_edge(in_tdata[TIME_W-1:0], in_tdata[TIME_W]));
      end
    end
    results_pending = expected_results.size();
  end

endmodule

FILE: tb/sv/edge_timed_bus_responder_top_tb.sv
// Top of the edge-timed bus responder testbench: clock, reset, edge stimulus and verdict.
module edge_timed_bus_responder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import etbr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RECEIVER_HOLD  = 400;

  // Register setting as the stimulus sees it
  typedef struct {
    int unsigned node;
    int unsigned listen;
    int unsigned rdata;
    int unsigned tdata;
    int unsigned pulse;
    int unsigned bitp;
    int unsigned on_addr;
    int unsigned off_addr;
  } bus_setup_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;   // [31:0] edge_time, [32] line_level, rest zero
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;  // [0] send_response, [32:1] response_word,
                                 // [33] word_received, [65:34] received_value,
                                 // [66] test_mode_active, rest zero
  logic              cfg_wen;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  int mismatch_count, results_pending, answers_seen, words_seen;
  int edges_sent = 0;
  int setups_applied = 0;
  int idle_cycles = 0;
  bus_setup_t cur;
  logic [TIME_W-1:0] t_last = '0;  // last edge time the block has taken
  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;
  bit hold_request = 1'b0;

  always #5ns clk = ~clk;

  edge_timed_bus_responder_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  edge_timed_bus_responder_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatch_count(mismatch_count), .results_pending(results_pending),
    .answers_seen(answers_seen), .words_seen(words_seen)
  );

  // Mostly back-to-back, sometimes a short pause, rarely a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One edge transfer; keeps t_last in step with what the block accepts
  task automatic drive_edge(input logic [TIME_W-1:0] stamp, input logic level);
    int idle;
    idle = sender_gaps ? gap_len() : 0;
    if (idle > 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DW-TIME_W-1){1'b0}}, level, stamp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (stamp - t_last >= 3 * cur.pulse) t_last = stamp;
    edges_sent++;
  endtask

  // Data edge inside the bit window (anywhere if the window is empty), now and then preceded by a bounce
  task automatic bit_edge(input logic level);
    int unsigned lo, hi, pick;
    lo = 3 * cur.pulse;
    hi = 2 * cur.bitp;
    if ($urandom_range(0, 15) == 0) drive_edge(t_last + $urandom_range(0, lo - 1), ~level);
    if (lo > hi) begin
      drive_edge(t_last + $urandom, level);
    end else begin
      pick = $urandom_range(0, 9);
      drive_edge(t_last + (pick == 0 ? lo : pick == 1 ? hi : $urandom_range(lo, hi)), level);
    end
  endtask

  // Edge after a silence long enough to restart framing
  task automatic restart_edge();
    int unsigned lo;
    lo = 2 * cur.bitp + 1;
    if (lo < 3 * cur.pulse) lo = 3 * cur.pulse;
    drive_edge(t_last + lo + ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 20000)),
               1'($urandom_range(0, 1)));
  endtask

  // MSB first
  task automatic send_bits(input logic [WORD_W-1:0] value, input int count);
    for (int i = count - 1; i >= 0; i--) bit_edge(value[i]);
  endtask

  // Mostly framed traffic for the current role, plus stray edges and bounces
  task automatic random_traffic(input int n_items);
    int stop_at, r;
    logic [ADDR_W-1:0] addr;
    stop_at = edges_sent + n_items;
    while (edges_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        drive_edge($urandom, 1'($urandom_range(0, 1)));
      end else if (r < 15) begin
        drive_edge(t_last + $urandom_range(0, 3 * cur.pulse - 1), 1'($urandom_range(0, 1)));
      end else if (cur.listen != 0) begin
        if ($urandom_range(0, 1)) restart_edge();
        r = $urandom_range(0, 99);
        addr = ADDR_W'(r < 40 ? cur.node : r < 55 ? cur.on_addr : r < 70 ? cur.off_addr :
                       $urandom_range(0, 255));
        send_bits(WORD_W'(addr), ADDR_W);
        // foreign address: its data word follows
        if (addr != cur.node && addr != cur.on_addr && addr != cur.off_addr) begin
          send_bits($urandom, DATA_BITS_DEF);
        end
      end else begin
        if ($urandom_range(0, 1)) restart_edge();
        // one word in eight is cut short
        send_bits($urandom, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 31) : DATA_BITS_DEF);
      end
    end
  endtask

  // Stop offering edges and wait until every result is out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DW'(value);
    @(negedge clk);
  endtask

  task automatic apply_setup(input bus_setup_t s);
    settle();
    write_reg(REG_NODE_ADDRESS, s.node);
    write_reg(REG_IS_LISTENER, s.listen);
    write_reg(REG_RESPONSE_DATA, s.rdata);
    write_reg(REG_TEST_DATA, s.tdata);
    write_reg(REG_PULSE_PERIOD, s.pulse);
    write_reg(REG_BIT_PERIOD, s.bitp);
    write_reg(REG_TEST_ON_ADDR, s.on_addr);
    write_reg(REG_TEST_OFF_ADDR, s.off_addr);
    cfg_wen <= 1'b0;
    cur = s;
    setups_applied++;
  endtask

  // Result side: random stalls and one long hold-off on request
  initial begin
    int idle;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (RECEIVER_HOLD) @(posedge clk);
      end else begin
        idle = receiver_gaps ? gap_len() : 0;
        if (idle > 0) begin
          out_tready <= 1'b0;
          repeat (idle - 1) @(posedge clk);
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    bus_setup_t s;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wen   = 1'b0;
    cfg_index = REG_NODE_ADDRESS;
    cfg_wdata = '0;
    cur = '{1, 1, 0, 0, 50, 500, 255, 254};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, on reset values
    drive_edge(32'hFFFF_FFFF, 1'b1);            // far from zero: restart
    drive_edge(32'h0000_0000, 1'b0);            // wraps to 1 us later: bounce, ignored
    drive_edge(t_last + 3 * cur.pulse, 1'b0);   // exactly three pulse periods
    drive_edge(t_last + 2 * cur.bitp, 1'b0);    // exactly two bit periods
    send_bits(32'h01, 6);                       // rest of own address: answered
    send_bits(32'hFF, ADDR_W);                  // test mode on
    send_bits(32'h01, ADDR_W);                  // answered with the test payload

    // Extreme settings; own address doubles as test-on address
    apply_setup('{255, 1, 24'hFF_FFFF, 24'hFF_FFFF, 1, 65535, 255, 0});
    random_traffic(60);
    // Slowest periods: every accepted edge restarts framing
    apply_setup('{0, 0, 0, 0, 65535, 65535, 0, 255});
    random_traffic(30);
    // Fastest periods: empty bit window
    apply_setup('{128, 1, 24'h80_0001, 24'h7F_FFFE, 1, 1, 0, 0});
    random_traffic(30);

    // Random settings; the role may change mid-frame across phases
    for (int phase = 0; phase < 11; phase++) begin
      s.node     = $urandom_range(0, 255);
      s.listen   = ($urandom_range(0, 9) < 6) ? 1 : 0;
      s.rdata    = $urandom_range(0, 24'hFF_FFFF);
      s.tdata    = $urandom_range(0, 24'hFF_FFFF);
      s.pulse    = $urandom_range(1, 300);
      s.bitp     = $urandom_range((3 * s.pulse + 1) / 2, 3000);
      s.on_addr  = ($urandom_range(0, 4) == 0) ? s.node : $urandom_range(0, 255);
      s.off_addr = ($urandom_range(0, 4) == 0) ? s.on_addr : $urandom_range(0, 255);
      apply_setup(s);
      sender_gaps   = ($urandom_range(0, 3) != 0);
      receiver_gaps = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // long result hold-off while edges keep coming
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
      end
      random_traffic(140);
    end

    settle();
    $display("Sent %0d edges under %0d register settings, with bounces, restarts and wraps.",
             edges_sent, setups_applied + 1);
    $display("Checked %0d address answers and %0d requester words; one long result stall.",
             answers_seen, words_seen);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
